>>> design/crlf_length_frame_deframer_top_defines.svh
// assertion macros for the crlf length frame deframer
// used by crlf_length_frame_deframer_top; expects clk and rst_n in scope
`ifndef CRLF_LENGTH_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define CRLF_LENGTH_FRAME_DEFRAMER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CRLF_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition never holds
`define CRLF_ASSERT_NEVER(label, cond, msg) \
    `CRLF_ASSERT_IMPLIES(label, 1'b1, !(cond), msg)

`endif

>>> design/crlf_pkg.sv
// shared types and constants of the crlf length frame deframer
// no dependencies
package crlf_pkg;

    localparam int LENGTH_BYTES_DEF = 4;
    localparam int QUEUE_DEPTH_DEF  = 4;
    localparam int MAX_W            = 25;
    localparam int IDX_W            = 3;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // register indexes of the configuration channel
    localparam logic [IDX_W-1:0] REG_CONT_CODE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_PING_CODE  = 3'd1;
    localparam logic [IDX_W-1:0] REG_PONG_CODE  = 3'd2;
    localparam logic [IDX_W-1:0] REG_CLOSE_CODE = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAX_BYTES  = 3'd4;

    localparam logic [7:0]       CONT_CODE_RST  = 8'd0;
    localparam logic [7:0]       PING_CODE_RST  = 8'd9;
    localparam logic [7:0]       PONG_CODE_RST  = 8'd10;
    localparam logic [7:0]       CLOSE_CODE_RST = 8'd8;
    localparam logic [MAX_W-1:0] MAX_BYTES_RST  = 25'd65536;

    typedef enum logic [2:0] {
        EV_BYTE  = 3'd0,
        EV_LAST  = 3'd1,
        EV_EMPTY = 3'd2,
        EV_PING  = 3'd3,
        EV_PONG  = 3'd4,
        EV_CLOSE = 3'd5,
        EV_ERROR = 3'd6,
        EV_OVF   = 3'd7
    } event_t;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LEN,
        PH_PAY
    } phase_t;

    typedef enum logic [2:0] {
        KIND_CONT,
        KIND_PING,
        KIND_PONG,
        KIND_CLOSE,
        KIND_DATA
    } kind_t;

    typedef struct packed {
        event_t     ev;
        logic [7:0] data;
        logic [7:0] kind;
    } res_t;

    typedef struct packed {
        logic valid;
        res_t res;
    } push_t;

endpackage

>>> design/crlf_front.sv
// front end: marker hunt, header parse, payload count and event classification
// depends on crlf_pkg
module crlf_front #(
    parameter int LENGTH_BYTES = crlf_pkg::LENGTH_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_fire,
    input  logic [7:0]                  rx_byte,
    input  logic                        cfg_fire,
    input  logic [crlf_pkg::IDX_W-1:0]  cfg_index,
    input  logic [crlf_pkg::MAX_W-1:0]  cfg_data,
    output crlf_pkg::push_t             push
);
    import crlf_pkg::*;

    localparam int RW     = 8 * LENGTH_BYTES;
    localparam int LCNT_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;

    logic [7:0]       cont_code_reg, ping_code_reg, pong_code_reg, close_code_reg;
    logic [MAX_W-1:0] max_bytes_reg;

    phase_t           phase_reg, phase_next;
    logic             cr_seen_reg, cr_seen_next;
    logic [7:0]       type_reg, type_next;
    logic [LCNT_W-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [MAX_W-1:0] total_reg, total_next;

    kind_t            kind;
    logic [RW-1:0]    rem_shift;
    logic [MAX_W:0]   total_inc;
    logic             end_frame;
    logic             had_byte;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_code_reg  <= CONT_CODE_RST;
            ping_code_reg  <= PING_CODE_RST;
            pong_code_reg  <= PONG_CODE_RST;
            close_code_reg <= CLOSE_CODE_RST;
            max_bytes_reg  <= MAX_BYTES_RST;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_CONT_CODE:  cont_code_reg  <= cfg_data[7:0];
                REG_PING_CODE:  ping_code_reg  <= cfg_data[7:0];
                REG_PONG_CODE:  pong_code_reg  <= cfg_data[7:0];
                REG_CLOSE_CODE: close_code_reg <= cfg_data[7:0];
                REG_MAX_BYTES:  max_bytes_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // priority: continuation, ping, pong, close
    always_comb
    begin
        if (type_reg == cont_code_reg)
            kind = KIND_CONT;
        else if (type_reg == ping_code_reg)
            kind = KIND_PING;
        else if (type_reg == pong_code_reg)
            kind = KIND_PONG;
        else if (type_reg == close_code_reg)
            kind = KIND_CLOSE;
        else
            kind = KIND_DATA;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            cr_seen_reg <= 1'b0;
            type_reg    <= '0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            total_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            cr_seen_reg <= cr_seen_next;
            type_reg    <= type_next;
            cnt_reg     <= cnt_next;
            rem_reg     <= rem_next;
            total_reg   <= total_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        cr_seen_next = cr_seen_reg;
        type_next    = type_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        total_next   = total_reg;
        rem_shift    = RW'({rem_reg, rx_byte});
        total_inc    = {1'b0, total_reg} + (MAX_W+1)'(1);
        end_frame    = 1'b0;
        had_byte     = 1'b0;
        push.valid   = 1'b0;
        push.res.ev   = EV_BYTE;
        push.res.data = 8'd0;
        push.res.kind = type_reg;

        if (in_fire)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (cr_seen_reg && rx_byte == CHAR_LF)
                    begin
                        phase_next   = PH_TYPE;
                        cr_seen_next = 1'b0;
                    end
                    else
                        cr_seen_next = (rx_byte == CHAR_CR);
                end
                PH_TYPE:
                begin
                    type_next  = rx_byte;
                    cnt_next   = '0;
                    rem_next   = '0;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    rem_next = rem_shift;
                    if (cnt_reg == LCNT_W'(LENGTH_BYTES - 1))
                    begin
                        cnt_next = '0;
                        if (rem_shift == '0)
                            end_frame = 1'b1;
                        else
                            phase_next = PH_PAY;
                    end
                    else
                        cnt_next = LCNT_W'(cnt_reg + 1'b1);
                end
                PH_PAY:
                begin
                    rem_next = rem_reg - RW'(1);
                    if (total_inc >= {1'b0, max_bytes_reg})
                    begin
                        total_next   = '0;
                        phase_next   = PH_HUNT;
                        cr_seen_next = 1'b0;
                        push.valid   = 1'b1;
                        push.res.ev  = EV_OVF;
                    end
                    else
                    begin
                        total_next = total_inc[MAX_W-1:0];
                        if (rem_reg == RW'(1))
                        begin
                            end_frame = 1'b1;
                            had_byte  = 1'b1;
                        end
                        else if (kind == KIND_CONT || kind == KIND_DATA)
                        begin
                            push.valid    = 1'b1;
                            push.res.data = rx_byte;
                        end
                    end
                end
                default:
                begin
                    phase_next   = PH_HUNT;
                    cr_seen_next = 1'b0;
                end
            endcase
        end

        if (end_frame)
        begin
            phase_next   = PH_HUNT;
            cr_seen_next = 1'b0;
            if (kind == KIND_CONT)
            begin
                push.valid    = had_byte;
                push.res.data = rx_byte;
            end
            else
            begin
                // message total survives only across continuation frames
                total_next = '0;
                push.valid = 1'b1;
                case (kind)
                    KIND_PING:  push.res.ev = EV_PING;
                    KIND_PONG:  push.res.ev = EV_PONG;
                    KIND_CLOSE: push.res.ev = EV_CLOSE;
                    default:
                    begin
                        if (had_byte)
                        begin
                            push.res.ev   = EV_LAST;
                            push.res.data = rx_byte;
                        end
                        else
                            push.res.ev = EV_EMPTY;
                    end
                endcase
            end
        end
    end

endmodule

>>> design/crlf_queue.sv
// result queue between the parser and the output channel
// depends on crlf_pkg
module crlf_queue #(
    parameter int QUEUE_DEPTH = crlf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  crlf_pkg::push_t   push,
    input  logic              pop,
    output crlf_pkg::res_t    head,
    output logic              not_empty,
    output logic              full
);
    import crlf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    res_t             mem_reg [QUEUE_DEPTH];
    res_t             head_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head      = head_reg;

    // head register follows the next read slot, taking a same-edge write directly
    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem_reg[wr_ptr_reg] <= push.res;
        if (push.valid && wr_ptr_reg == rd_ptr_next)
            head_reg <= push.res;
        else
            head_reg <= mem_reg[rd_ptr_next];
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push.valid)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : PTR_W'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : PTR_W'(rd_ptr_reg + 1'b1);
        count_next  = count_reg;
        if (push.valid && !do_pop)
            count_next = CNT_W'(count_reg + 1'b1);
        else if (!push.valid && do_pop)
            count_next = CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/crlf_length_frame_deframer_top.sv
// top level of the crlf length frame deframer: parser front end and result queue
// depends on crlf_pkg, crlf_front, crlf_queue and the defines header
//
// usage:
//   s_* takes one received byte per request in s_tdata. the parser hunts for
//   CR LF, reads a type byte and a LENGTH_BYTES big-endian length, then the
//   payload. each byte gives zero or one event on m_*: m_tuser is the event
//   code, m_tdata holds the payload byte (low byte) and the frame type.
//   cfg_* writes the four type codes and the message size limit by index;
//   cfg_ready is always high; writes must go in while no request is in flight,
//   which the block does not check. an event is queued as its byte is taken.
//   throughput: one byte per cycle while s_tready is high; the parser adds no stall.
//   the QUEUE_DEPTH entry queue absorbs output stalls; s_tready drops only
//   while the queue is full, and is high again right after m_* takes a result.
//   reset: parser hunts for the marker, queue empties, registers take their
//   default codes (continuation 0, ping 9, pong 10, close 8, limit 65536).
`include "crlf_length_frame_deframer_top_defines.svh"

module crlf_length_frame_deframer_top #(
    parameter int LENGTH_BYTES = crlf_pkg::LENGTH_BYTES_DEF,
    parameter int QUEUE_DEPTH  = crlf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,    // [7:0] rx_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,    // [7:0] data_byte, [15:8] frame_kind
    output logic [2:0]                  m_tuser,    // [2:0] event_res
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [crlf_pkg::IDX_W-1:0]  cfg_index,
    input  logic [crlf_pkg::MAX_W-1:0]  cfg_data
);
    import crlf_pkg::*;

    push_t push;
    res_t  head;
    logic  q_not_empty;
    logic  q_full;
    logic  in_fire;

    assign s_tready  = !q_full;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    crlf_front #(
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .rx_byte   (s_tdata),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    crlf_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (m_tready),
        .head      (head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    assign m_tvalid = q_not_empty;
    assign m_tdata  = {head.kind, head.data};
    assign m_tuser  = head.ev;

    // a result only appears while the queue has room for it
    `CRLF_ASSERT_IMPLIES(a_push_room, push.valid, !q_full, "push into full queue")

    // the queue fills only through a push
    `CRLF_ASSERT_IMPLIES(a_full_by_push, $fell(s_tready), $past(push.valid),
        "queue became full without a push")

    // only payload events carry a data byte
    `CRLF_ASSERT_IMPLIES(a_data_zero,
        m_tvalid && m_tuser != EV_BYTE && m_tuser != EV_LAST, m_tdata[7:0] == 8'd0,
        "non-payload event with data byte")

    `CRLF_ASSERT_NEVER(a_no_error, m_tvalid && m_tuser == EV_ERROR,
        "reserved error event produced")

endmodule

>>> bench/frame_event_sb_pkg.sv
// scoreboard for the crlf length frame deframer bench: predicts the event stream
// from accepted rx bytes and register writes, then checks results in order
// depends on crlf_pkg
package frame_event_sb_pkg;

    import crlf_pkg::*;

    class frame_event_scoreboard;

        // register copies
        logic [7:0]       cont_code;
        logic [7:0]       ping_code;
        logic [7:0]       pong_code;
        logic [7:0]       close_code;
        logic [MAX_W-1:0] msg_limit;

        // parser state
        phase_t      ph;
        bit          cr_pending;
        logic [7:0]  ftype;
        int          len_cnt;
        logic [31:0] remaining;
        logic [32:0] msg_total;

        res_t pending_events[$];
        int   errors;
        int   n_bytes;
        int   n_events;
        int   ev_seen[8];

        function new();
            cont_code  = CONT_CODE_RST;
            ping_code  = PING_CODE_RST;
            pong_code  = PONG_CODE_RST;
            close_code = CLOSE_CODE_RST;
            msg_limit  = MAX_BYTES_RST;
            ph         = PH_HUNT;
            cr_pending = 1'b0;
            ftype      = '0;
            len_cnt    = 0;
            remaining  = '0;
            msg_total  = '0;
            errors     = 0;
            n_bytes    = 0;
            n_events   = 0;
            foreach (ev_seen[i]) ev_seen[i] = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [MAX_W-1:0] val);
            case (idx)
                REG_CONT_CODE:  cont_code  = val[7:0];
                REG_PING_CODE:  ping_code  = val[7:0];
                REG_PONG_CODE:  pong_code  = val[7:0];
                REG_CLOSE_CODE: close_code = val[7:0];
                REG_MAX_BYTES:  msg_limit  = val;
                default: ;
            endcase
        endfunction

        // equal codes resolve in priority order
        function kind_t classify();
            if (ftype == cont_code) return KIND_CONT;
            if (ftype == ping_code) return KIND_PING;
            if (ftype == pong_code) return KIND_PONG;
            if (ftype == close_code) return KIND_CLOSE;
            return KIND_DATA;
        endfunction

        function void add_event(event_t e, logic [7:0] d);
            res_t r;
            r.ev   = e;
            r.data = d;
            r.kind = ftype;
            pending_events.push_back(r);
        endfunction

        function void end_frame(bit had_byte, logic [7:0] b);
            kind_t k;
            k = classify();
            ph = PH_HUNT;
            cr_pending = 1'b0;
            if (k == KIND_CONT)
            begin
                if (had_byte) add_event(EV_BYTE, b);
                return;
            end
            msg_total = '0;
            case (k)
                KIND_PING:  add_event(EV_PING, 8'h00);
                KIND_PONG:  add_event(EV_PONG, 8'h00);
                KIND_CLOSE: add_event(EV_CLOSE, 8'h00);
                default:
                    if (had_byte) add_event(EV_LAST, b);
                    else add_event(EV_EMPTY, 8'h00);
            endcase
        endfunction

        // one accepted rx byte request
        function void note_rx_byte(logic [7:0] b);
            kind_t k;
            n_bytes++;
            case (ph)
                PH_HUNT:
                    if (cr_pending && b == CHAR_LF)
                    begin
                        ph = PH_TYPE;
                        cr_pending = 1'b0;
                    end
                    else
                    begin
                        cr_pending = (b == CHAR_CR);
                    end
                PH_TYPE:
                begin
                    ftype = b;
                    len_cnt = 0;
                    remaining = '0;
                    ph = PH_LEN;
                end
                PH_LEN:
                begin
                    remaining = {remaining[23:0], b};
                    if (len_cnt + 1 >= LENGTH_BYTES_DEF)
                    begin
                        len_cnt = 0;
                        if (remaining == 0) end_frame(1'b0, 8'h00);
                        else ph = PH_PAY;
                    end
                    else
                    begin
                        len_cnt++;
                    end
                end
                default:
                begin
                    msg_total = msg_total + 33'd1;
                    remaining = remaining - 32'd1;
                    if (msg_total >= {8'd0, msg_limit})
                    begin
                        msg_total = '0;
                        ph = PH_HUNT;
                        cr_pending = 1'b0;
                        add_event(EV_OVF, 8'h00);
                    end
                    else if (remaining == 0)
                    begin
                        end_frame(1'b1, b);
                    end
                    else
                    begin
                        k = classify();
                        // control payloads are counted but give no event
                        if (k == KIND_CONT || k == KIND_DATA) add_event(EV_BYTE, b);
                    end
                end
            endcase
        endfunction

        function void check_event(logic [2:0] ev, logic [7:0] data, logic [7:0] kind);
            res_t want;
            n_events++;
            ev_seen[ev]++;
            if (pending_events.size() == 0)
            begin
                $error("unexpected event: event_res %0d data_byte 0x%02h frame_kind 0x%02h",
                       ev, data, kind);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            if (want.ev !== ev)
            begin
                $error("event_res: expected %0d, actual %0d", want.ev, ev);
                errors++;
            end
            if (want.data !== data)
            begin
                $error("data_byte: expected 0x%02h, actual 0x%02h", want.data, data);
                errors++;
            end
            if (want.kind !== kind)
            begin
                $error("frame_kind: expected 0x%02h, actual 0x%02h", want.kind, kind);
                errors++;
            end
        endfunction

        function void close_out();
            if (pending_events.size() != 0)
            begin
                $error("%0d expected events never arrived", pending_events.size());
                errors += pending_events.size();
            end
        endfunction

    endclass

endpackage

>>> bench/crlf_length_frame_deframer_top_tb.sv
// bench top for crlf_length_frame_deframer_top: directed and random byte streams
// over several register settings and handshake idling patterns
// depends on crlf_pkg, frame_event_sb_pkg and the deframer rtl
module crlf_length_frame_deframer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import crlf_pkg::*;
    import frame_event_sb_pkg::*;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [15:0]         m_tdata;
    logic [2:0]          m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [MAX_W-1:0]    cfg_data  = '0;

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int n_settings      = 0;

    frame_event_scoreboard sb = new();

    crlf_length_frame_deframer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_event(m_tuser, m_tdata[7:0], m_tdata[15:8]);
    end

    initial
    begin
        #5_000_000;
        $display("crlf_length_frame_deframer_top test failed");
        $finish;
    end

    // valid stays high into the next request unless the sender idles
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        sb.note_rx_byte(b);
    endtask

    // hold the sender until every expected event is out, then let the queue settle
    task automatic settle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (sb.pending_events.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_regs(input logic [7:0] c, input logic [7:0] p, input logic [7:0] q,
                              input logic [7:0] x, input logic [MAX_W-1:0] lim);
        logic [IDX_W-1:0] idx [5];
        logic [MAX_W-1:0] val [5];
        idx = '{REG_CONT_CODE, REG_PING_CODE, REG_PONG_CODE, REG_CLOSE_CODE, REG_MAX_BYTES};
        val = '{{17'd0, c}, {17'd0, p}, {17'd0, q}, {17'd0, x}, lim};
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return CHAR_CR;
            3:       return CHAR_LF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mostly well-formed frames with random content, some noise and truncation
    task automatic send_random_frame(input logic [MAX_W-1:0] lim);
        logic [7:0]  ftype;
        logic [31:0] len;
        int          npay;
        int          nnoise;
        int          ncr;
        int          sel;
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2: ftype = sb.cont_code;
            3:       ftype = sb.ping_code;
            4:       ftype = sb.pong_code;
            5:       ftype = sb.close_code;
            default: ftype = 8'($urandom_range(255));
        endcase
        sel = $urandom_range(19);
        if (sel == 0)
            len = '0;
        else if (sel == 1 && lim <= 64)
            len = $urandom;
        else
            len = $urandom_range(1, 10);
        if (len > 32'd64)
            npay = int'(lim) + $urandom_range(0, 3);
        else
            npay = int'(len);
        if ($urandom_range(9) == 0)
            npay = $urandom_range(0, 12);
        nnoise = ($urandom_range(4) == 0) ? $urandom_range(1, 4) : 0;
        ncr = ($urandom_range(5) == 0) ? $urandom_range(2, 3) : 1;

        repeat (nnoise) push_byte(pick_byte());
        repeat (ncr) push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        push_byte(ftype);
        for (int i = LENGTH_BYTES_DEF - 1; i >= 0; i--)
            push_byte(len[8*i +: 8]);
        repeat (npay) push_byte(pick_byte());
    endtask

    initial
    begin
        logic [7:0]       c, p, q, x;
        logic [MAX_W-1:0] lim;
        logic [7:0]       seq[$];
        int               target;
        int               pause_at;
        bit               paused;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            c = 8'($urandom_range(255));
            p = 8'($urandom_range(255));
            q = 8'($urandom_range(255));
            x = 8'($urandom_range(255));
            case (ph)
                0:
                begin
                    c = CONT_CODE_RST;
                    p = PING_CODE_RST;
                    q = PONG_CODE_RST;
                    x = CLOSE_CODE_RST;
                    lim = MAX_BYTES_RST;
                end
                1:
                begin
                    // overlapping codes at the extremes, the first payload byte of every frame overflows
                    c = 8'hFF;
                    p = 8'h00;
                    q = 8'hFF;
                    x = 8'h00;
                    lim = 25'd1;
                end
                2: lim = MAX_W'($urandom_range(2, 24));
                3:
                begin
                    p = c;
                    q = c;
                    x = c;
                    lim = 25'h1000000;
                end
                4: lim = MAX_W'($urandom_range(1, 8));
                default: lim = MAX_W'($urandom_range(25, 300));
            endcase
            write_regs(c, p, q, x, lim);

            case (ph % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 55;
                    stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct = 55;
                end
                default:
                begin
                    sender_idle_pct = 29;
                    stall_pct = 29;
                end
            endcase

            if (ph == 0)
            begin
                // lone lf, stray bytes, cr run, then empty frames of each kind,
                // a continuation with payload, a data end and a ping with payload
                seq = '{CHAR_LF, 8'h00, 8'hFF, CHAR_CR, CHAR_CR, CHAR_CR, CHAR_LF,
                        8'h41, 8'h00, 8'h00, 8'h00, 8'h00,
                        CHAR_CR, CHAR_LF, CONT_CODE_RST, 8'h00, 8'h00, 8'h00, 8'h00,
                        CHAR_CR, CHAR_LF, PING_CODE_RST, 8'h00, 8'h00, 8'h00, 8'h00,
                        CHAR_CR, CHAR_LF, PONG_CODE_RST, 8'h00, 8'h00, 8'h00, 8'h00,
                        CHAR_CR, CHAR_LF, CLOSE_CODE_RST, 8'h00, 8'h00, 8'h00, 8'h00,
                        CHAR_CR, CHAR_LF, CONT_CODE_RST, 8'h00, 8'h00, 8'h00, 8'h02,
                        8'h00, 8'hFF,
                        CHAR_CR, CHAR_LF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h55,
                        CHAR_CR, CHAR_LF, PING_CODE_RST, 8'h00, 8'h00, 8'h00, 8'h02,
                        8'hAA, CHAR_CR};
                foreach (seq[i]) push_byte(seq[i]);
            end

            target = sb.n_bytes + 170;
            pause_at = sb.n_bytes + 80;
            paused = 1'b0;
            while (sb.n_bytes < target)
            begin
                send_random_frame(lim);
                if (!paused && sb.n_bytes >= pause_at)
                begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        settle();
        sb.close_out();
        $display("run covered %0d rx bytes and %0d events over %0d register settings",
                 sb.n_bytes, sb.n_events, n_settings);
        $display(
            "events: %0d byte, %0d last, %0d empty, %0d ping, %0d pong, %0d close, %0d ovf",
            sb.ev_seen[EV_BYTE], sb.ev_seen[EV_LAST], sb.ev_seen[EV_EMPTY],
            sb.ev_seen[EV_PING], sb.ev_seen[EV_PONG], sb.ev_seen[EV_CLOSE],
            sb.ev_seen[EV_OVF]);
        if (sb.errors == 0)
            $display("crlf_length_frame_deframer_top test passed");
        else
            $display("crlf_length_frame_deframer_top test failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/crlf_pkg.sv
design/crlf_front.sv
design/crlf_queue.sv
design/crlf_length_frame_deframer_top.sv
bench/frame_event_sb_pkg.sv
bench/crlf_length_frame_deframer_top_tb.sv
